// ===== rtl/core/bdq_pkg.sv =====
// Shared types, sizes and helpers for the bounded indexed deque.
// Used by the channel interfaces and every module of the block; no dependencies.
package bdq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned FILL_W   = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_DROP_BACK  = 3'd4,
    MODE_DROP_FRONT = 3'd5,
    MODE_READ       = 3'd6
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] elem_t;

  // request transaction payload
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] push_value;
    logic [POS_W-1:0]   position;
  } req_t;

  // response transaction payload
  typedef struct packed {
    logic [VALUE_W-1:0]  out_value;
    logic [FILL_W-1:0]   fill_count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // slot store access for one request
  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    elem_t wdata;
    logic  re;
    ptr_t  raddr;
  } mem_req_t;

  // response fields settled in the request cycle
  typedef struct packed {
    logic    use_data;
    cnt_t    fill;
    status_e status;
  } rsp_meta_t;

  // (base + offset) modulo DEPTH, both operands below DEPTH
  function automatic ptr_t wrap_add(ptr_t base, cnt_t offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

// ===== rtl/core/bdq_req_if.sv =====
// Request channel: valid/ready handshake carrying a req_t payload.
// Depends on bdq_pkg.
interface bdq_req_if;
  logic           valid;
  logic           ready;
  bdq_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bdq_rsp_if.sv =====
// Response channel: valid/ready handshake carrying an rsp_t payload.
// Depends on bdq_pkg.
interface bdq_rsp_if;
  logic           valid;
  logic           ready;
  bdq_pkg::rsp_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bdq_ctrl.sv =====
// Front pointer and fill count, request decode and slot address generation.
// Depends on bdq_pkg.
module bdq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bdq_pkg::req_t       req_i,
  output bdq_pkg::mem_req_t   mem_o,
  output bdq_pkg::rsp_meta_t  meta_o
);
  import bdq_pkg::*;

  ptr_t      front_q, front_d;
  cnt_t      count_q, count_d;
  mem_req_t  mem;
  logic      full, empty;

  assign full  = (count_q >= CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    front_d        = front_q;
    count_d        = count_q;
    mem            = '0;
    mem.wdata      = DATA_WIDTH'(req_i.push_value);
    meta_o         = '0;
    meta_o.status  = ST_OK;

    unique case (mode_e'(req_i.mode)) inside
      MODE_PUSH_BACK: begin
        if (full) begin
          meta_o.status = ST_FULL;
        end else begin
          mem.we    = 1'b1;
          mem.waddr = wrap_add(front_q, count_q);
          count_d   = count_q + 1'b1;
        end
      end
      MODE_PUSH_FRONT: begin
        if (full) begin
          meta_o.status = ST_FULL;
        end else begin
          front_d   = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
          mem.we    = 1'b1;
          mem.waddr = front_d;
          count_d   = count_q + 1'b1;
        end
      end
      MODE_POP_BACK, MODE_DROP_BACK: begin
        if (empty) begin
          meta_o.status = ST_EMPTY;
        end else begin
          mem.re          = (mode_e'(req_i.mode) == MODE_POP_BACK);
          meta_o.use_data = mem.re;
          mem.raddr       = wrap_add(front_q, count_q - 1'b1);
          count_d         = count_q - 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_DROP_FRONT: begin
        if (empty) begin
          meta_o.status = ST_EMPTY;
        end else begin
          mem.re          = (mode_e'(req_i.mode) == MODE_POP_FRONT);
          meta_o.use_data = mem.re;
          mem.raddr       = front_q;
          front_d         = wrap_add(front_q, CNT_W'(1));
          count_d         = count_q - 1'b1;
        end
      end
      MODE_READ: begin
        if (32'(req_i.position) >= 32'(count_q)) begin
          meta_o.status = ST_RANGE;
        end else begin
          mem.re          = 1'b1;
          meta_o.use_data = 1'b1;
          mem.raddr       = wrap_add(front_q, CNT_W'(req_i.position));
        end
      end
      default: ;  // undefined mode: no effect
    endcase

    meta_o.fill = count_d;

    mem_o       = mem;
    mem_o.we    = mem.we & accept_i;
    mem_o.re    = mem.re & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/bdq_store.sv =====
// Slot store: DEPTH x DATA_WIDTH memory, one write and one registered read port.
// Depends on bdq_pkg.
module bdq_store (
  input  logic               clk_i,
  input  bdq_pkg::mem_req_t  mem_i,
  output bdq_pkg::elem_t     rdata_o
);
  import bdq_pkg::*;

  elem_t mem_q [DEPTH];
  elem_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
  end

  // read data holds while no read is issued, so a stalled response keeps it
  always_ff @(posedge clk_i) begin
    if (mem_i.re) begin
      rdata_q <= mem_q[mem_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bounded_deque_indexed_core.sv =====
// Bounded indexed deque: circular buffer of DEPTH elements with push, pop, drop, read.
// Response valid is registered and rises in the cycle after the request transaction.
// Throughput: one request per cycle; the single registered slot-store read port and
// the response register set this. Requests stall while a response waits on ready.
// Reset: front pointer, fill count and response valid clear; slot store is not reset.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl and bdq_store.
module bounded_deque_indexed_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  // ---------------------------------------------------------------------------
  // Handshake
  // A request is taken whenever the response register is empty or is being
  // drained in the same cycle, so back-to-back requests flow at full rate.
  // ---------------------------------------------------------------------------
  logic      accept;
  logic      rsp_valid_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Control: decode, pointer/count update, slot addresses
  // ---------------------------------------------------------------------------
  mem_req_t  mem_req;
  rsp_meta_t meta;

  bdq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i.payload),
    .mem_o    (mem_req),
    .meta_o   (meta)
  );

  // ---------------------------------------------------------------------------
  // Slot store. A write and the next request's read never meet in one cycle
  // (each request does at most one of them), so the registered read always
  // sees earlier pushes.
  // ---------------------------------------------------------------------------
  elem_t rdata;

  bdq_store u_store (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------------
  // Response register: status and count are captured alongside the read, the
  // data itself comes from the store's read register.
  // ---------------------------------------------------------------------------
  rsp_meta_t meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= meta;
    end
  end

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.payload.out_value  = meta_q.use_data ? VALUE_W'(rdata) : '0;
  assign rsp_o.payload.fill_count = FILL_W'(meta_q.fill);
  assign rsp_o.payload.status     = meta_q.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (meta_q.fill <= CNT_W'(DEPTH)))
    else $error("fill count beyond capacity");

  a_full_refusal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && meta_q.status == ST_FULL) |-> (meta_q.fill == CNT_W'(DEPTH)))
    else $error("push refused while not full");

  a_empty_refusal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && meta_q.status == ST_EMPTY) |-> (meta_q.fill == '0))
    else $error("pop or drop refused while not empty");

  a_data_only_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && meta_q.use_data) |-> (meta_q.status == ST_OK))
    else $error("data returned on a refused request");

endmodule

// ===== bench/bdq_deque_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded indexed deque: watches both channels, keeps its own deque
// state and compares every response transaction field by field with the prediction.
// Depends on bdq_pkg, bdq_req_if and bdq_rsp_if.
module bdq_deque_checker (
  input  logic clk_i,
  input  logic rst_ni,
  bdq_req_if   req_i,
  bdq_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);
  import bdq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  elem_t       slot_mirror [DEPTH];
  ptr_t        front_slot = '0;
  int unsigned held_count = 0;
  rsp_t        answers_due [$];
  int          mismatches = 0;
  int          rsp_seen   = 0;

  // physical slot of the element at a given distance from the front
  function automatic int unsigned slot_index(int unsigned offset);
    return (int'(front_slot) + offset) % DEPTH;
  endfunction

  // applies one request to the mirrored deque and returns the answer it owes
  function automatic rsp_t deque_answer(req_t req);
    rsp_t ans;
    ans = '0;
    case (req.mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (held_count >= DEPTH) begin
          ans.status = ST_FULL;
        end else if (req.mode == MODE_PUSH_FRONT) begin
          front_slot = ptr_t'((int'(front_slot) + DEPTH - 1) % DEPTH);
          slot_mirror[front_slot] = elem_t'(req.push_value);
          held_count++;
        end else begin
          slot_mirror[slot_index(held_count)] = elem_t'(req.push_value);
          held_count++;
        end
      end
      MODE_POP_BACK, MODE_DROP_BACK: begin
        if (held_count == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          if (req.mode == MODE_POP_BACK) begin
            ans.out_value = VALUE_W'(slot_mirror[slot_index(held_count - 1)]);
          end
          held_count--;
        end
      end
      MODE_POP_FRONT, MODE_DROP_FRONT: begin
        if (held_count == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          if (req.mode == MODE_POP_FRONT) begin
            ans.out_value = VALUE_W'(slot_mirror[front_slot]);
          end
          front_slot = ptr_t'(slot_index(1));
          held_count--;
        end
      end
      MODE_READ: begin
        if (req.position >= held_count) begin
          ans.status = ST_RANGE;
        end else begin
          ans.out_value = VALUE_W'(slot_mirror[slot_index(req.position)]);
        end
      end
      default: ;  // unused mode leaves the deque alone
    endcase
    ans.fill_count = FILL_W'(held_count);
    return ans;
  endfunction

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni) begin
      // response first: it always belongs to an earlier request
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.payload;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("bdq check: response %0d unexpected, value=%h fill=%0d status=%0d",
                     rsp_seen, got.out_value, got.fill_count, got.status);
          end
        end else begin
          want = answers_due.pop_front();
          if (got.out_value !== want.out_value || got.fill_count !== want.fill_count ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("bdq check: response %0d expected value=%h fill=%0d status=%0d",
                       rsp_seen, want.out_value, want.fill_count, want.status);
              $display("bdq check:              got value=%h fill=%0d status=%0d",
                       got.out_value, got.fill_count, got.status);
            end
          end
        end
        rsp_seen++;
      end
      if (req_i.valid && req_i.ready) begin
        answers_due.push_back(deque_answer(req_i.payload));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= answers_due.size();
  end

endmodule

// ===== bench/bounded_deque_indexed_core_test.sv =====
`timescale 1ns / 100ps
// Testbench top for bounded_deque_indexed_core: clock, reset, request stimulus,
// response back-pressure, an idle watchdog and the verdict.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, the core and bdq_deque_checker.
module bounded_deque_indexed_core_test;
  import bdq_pkg::*;

  localparam int RANDOM_ITEMS  = 1000;
  // cycles without any transaction before the run is declared hung; the worst
  // legitimate quiet spell is a starved receiver, far below this
  localparam int QUIET_LIMIT   = 2000;
  // response is registered, in the cycle after its request; a little margin on top
  localparam int SETTLE_CYCLES = 4;
  localparam int RESET_CYCLES  = 11;
  // mode code with no meaning: the block answers it but leaves the deque alone
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // random phases steer the fill level so both full and empty get hit often
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  // receiver back-pressure styles
  typedef enum int {RX_FREE, RX_COIN, RX_EVERY_FOURTH, RX_STARVED} rx_style_e;

  logic        clk;
  logic        rst_n;
  int          fail_total;
  int          answers_owed;
  int          quiet_cycles = 0;
  int unsigned fill_guess   = 0;  // stimulus-side fill level, only for steering
  int unsigned burst_left   = 8;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_indexed_core u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bdq_deque_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_total),
    .pending_o    (answers_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: counts edges at which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[bounded_deque_indexed_core] ERROR");
    $finish;
  end

  // Receiver: switches at random between back-pressure styles, including spells of no stalling at all.
  initial begin
    rx_style_e   style;
    int unsigned style_left;
    int unsigned beat;
    style         = RX_FREE;
    style_left    = 0;
    beat          = 0;
    rsp_if.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        style      = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(16, 96);
      end else begin
        style_left--;
      end
      beat++;
      case (style)
        RX_FREE:         rsp_if.ready <= 1'b1;
        RX_COIN:         rsp_if.ready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: rsp_if.ready <= (beat % 4 == 0);
        default:         rsp_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Presents one request and holds it until the transaction completes. Requests
  // go out in bursts; at the end of a burst valid drops for a random gap and
  // the payload carries junk meanwhile.
  task automatic issue(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                       input logic [POS_W-1:0] pos);
    req_t        item;
    int unsigned gap;
    item.mode       = mode;
    item.push_value = value;
    item.position   = pos;
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // track the fill level the way the deque will
    case (mode) inside
      MODE_PUSH_BACK, MODE_PUSH_FRONT: if (fill_guess < DEPTH) fill_guess++;
      MODE_POP_BACK, MODE_POP_FRONT, MODE_DROP_BACK, MODE_DROP_FRONT: begin
        if (fill_guess > 0) fill_guess--;
      end
      default: ;
    endcase
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
      gap        = $urandom_range(1, 12);
      req_if.valid   <= 1'b0;
      req_if.payload <= req_t'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    phase_e             phase;
    int unsigned        phase_left;
    int unsigned        roll;
    int unsigned        counted;

    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    phase          = PH_MIXED;
    phase_left     = 0;
    counted        = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part -----------------------------------------------------
    // every read and removal refused on an empty deque; the unused mode answers without effect
    issue(MODE_READ,       32'h0,         6'd0);
    issue(MODE_POP_BACK,   32'h0,         6'd0);
    issue(MODE_POP_FRONT,  32'h0,         6'd0);
    issue(MODE_DROP_BACK,  32'h0,         6'd0);
    issue(MODE_DROP_FRONT, 32'h0,         6'd0);
    issue(MODE_UNUSED,     32'hFFFF_FFFF, 6'd63);
    // value extremes at both ends; front pushes wrap the front pointer
    issue(MODE_PUSH_BACK,  32'h0000_0000, 6'd0);
    issue(MODE_PUSH_BACK,  32'hFFFF_FFFF, 6'd63);
    issue(MODE_PUSH_FRONT, 32'hA5A5_A5A5, 6'd0);
    issue(MODE_PUSH_FRONT, 32'h5A5A_5A5A, 6'd0);
    // reads inside, at the count and at the top position
    issue(MODE_READ,       32'h0,         6'd0);
    issue(MODE_READ,       32'h0,         6'd3);
    issue(MODE_READ,       32'h0,         6'd4);
    issue(MODE_READ,       32'h0,         6'd63);
    issue(MODE_UNUSED,     32'h1234_5678, 6'd1);
    // take everything back out through every removal mode
    issue(MODE_POP_BACK,   32'h0,         6'd0);
    issue(MODE_POP_FRONT,  32'h0,         6'd0);
    issue(MODE_DROP_BACK,  32'h0,         6'd0);
    issue(MODE_DROP_FRONT, 32'h0,         6'd0);
    issue(MODE_READ,       32'h0,         6'd0);

    // --- random part -------------------------------------------------------
    // Fill phases run the deque up to full and push against it, drain phases
    // empty it and keep popping, mixed phases wander in between.
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL: begin
          if (roll < 70) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
          end else if (roll < 90) begin
            mode = MODE_READ;
          end else begin
            mode = 3'($urandom_range(2, 5));
          end
        end
        PH_DRAIN: begin
          if (roll < 70) begin
            mode = 3'($urandom_range(2, 5));
          end else if (roll < 80) begin
            mode = ($urandom_range(0, 1) != 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
          end else begin
            mode = MODE_READ;
          end
        end
        default: mode = 3'($urandom_range(0, 6));
      endcase
      if (roll == 99) mode = MODE_UNUSED;

      case ($urandom_range(0, 15))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase

      // reads mostly land inside the deque, sometimes exactly at the count
      roll = $urandom_range(0, 9);
      if (mode == MODE_READ && roll < 8 && fill_guess > 0) begin
        pos = POS_W'($urandom_range(0, fill_guess - 1));
      end else if (mode == MODE_READ && roll == 8) begin
        pos = POS_W'(fill_guess);
      end else begin
        pos = POS_W'($urandom);
      end

      issue(mode, value, pos);
      if (mode != MODE_UNUSED) counted++;
    end

    // --- wind down ---------------------------------------------------------
    req_if.valid <= 1'b0;
    // let the checker take the last request into account before polling the owed answers
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_total == 0 && answers_owed == 0) begin
      $display("[bounded_deque_indexed_core] OK");
    end else begin
      $display("[bounded_deque_indexed_core] ERROR");
    end
    $finish;
  end

endmodule
